/* rtl/core/stg_pkg.sv */
// Shared types, constants and the quarter-wave sine table for the swept tone generator.
// Depends on nothing; every other file of the block refers to it by scoped names.
package stg_pkg;

   localparam int unsigned SINE_TABLE_DEPTH = 256;
   localparam int unsigned SINE_IDX_W       = $clog2(SINE_TABLE_DEPTH);
   localparam int unsigned MID_QUEUE_DEPTH  = 4;
   localparam int unsigned RSP_QUEUE_DEPTH  = 4;
   localparam int unsigned CSR_INDEX_W      = 3;
   localparam int unsigned CSR_DATA_W       = 32;

   localparam logic [15:0] FULL_SCALE   = 16'd32767;
   localparam logic [31:0] UNITY_SWEEP  = 32'h4000_0000;
   localparam logic [63:0] HALF_PI_Q30  = 64'd1686629713;
   localparam logic [63:0] ONE_Q30      = 64'd1073741824;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_START_INCREMENT = 3'd0,
      CSR_SWEEP_RATIO     = 3'd1,
      CSR_WAVE_SHAPE      = 3'd2,
      CSR_START_GAIN      = 3'd3,
      CSR_DECAY_RATIO     = 3'd4,
      CSR_TONE_LENGTH     = 3'd5,
      CSR_START_DELAY     = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      WAVE_SINE     = 2'd0,
      WAVE_SQUARE   = 2'd1,
      WAVE_TRIANGLE = 2'd2,
      WAVE_SAW      = 2'd3
   } wave_shape_type;

   typedef struct packed {
      logic [30:0]    start_increment;
      logic [31:0]    sweep_ratio;
      wave_shape_type wave_shape;
      logic [15:0]    start_gain;
      logic [31:0]    decay_ratio;
      logic [15:0]    tone_length;
      logic [15:0]    start_delay;
   } csr_type;

   // One sample's work as handed from the sequencer to the waveform pipeline.
   typedef struct packed {
      logic [31:0]    phase;
      logic [31:0]    gain;
      wave_shape_type shape;
      logic           tone;
      logic           busy;
      logic           last;
   } tone_item_type;

   typedef struct packed {
      logic signed [15:0] sample;
      logic               busy_res;
      logic               last;
   } rsp_beat_type;

   typedef logic [15:0] sine_rom_type [SINE_TABLE_DEPTH];

   // Quarter-wave sine sampled at bin centers, evaluated with a fixed-point
   // Taylor series in Q2.30 and rounded to Q1.15.
   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      logic [63:0]  x;
      logic [63:0]  x2;
      logic [63:0]  t;
      logic [63:0]  s;
      logic [63:0]  v;
      for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
         // The table depth is a power of two, so dividing by twice the depth is a shift.
         x  = (HALF_PI_Q30 * (64'(2 * i) + 64'd1)) >> (SINE_IDX_W + 1);
         x2 = (x * x) >> 30;
         t  = ONE_Q30 - x2 / 64'd110;
         t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
         t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
         t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
         t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
         s  = (x * t) >> 30;
         v  = (s * 64'(FULL_SCALE) + 64'h2000_0000) >> 30;
         rom[i] = (v > 64'(FULL_SCALE)) ? FULL_SCALE : v[15:0];
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine_rom();

endpackage

/* rtl/core/stg_queue.sv */
// Small show-ahead queue built from registers, used between the sequencer and the
// waveform pipeline and as the result buffer. Depends on stg_pkg for its default depth.
module stg_queue #(
   parameter int unsigned DEPTH  = stg_pkg::MID_QUEUE_DEPTH,
   parameter int unsigned DATA_W = $bits(stg_pkg::tone_item_type)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  logic [DATA_W-1:0]            push_data,
   input  logic                         pop,
   output logic [DATA_W-1:0]            pop_data,
   output logic                         full,
   output logic                         empty,
   output logic [$clog2(DEPTH+1)-1:0]   count
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign count    = count_ff;
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue holds more entries than its depth");

   a_count_grows: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not grow on a lone push");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("empty queue with pointers apart");
`endif

endmodule

/* rtl/core/stg_front.sv */
// Sequencer of the swept tone generator: configuration registers, restart and delay
// handling, phase accumulation and the geometric sweep and decay. Depends on stg_pkg.
module stg_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [stg_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [stg_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic                                 req_push,
   input  logic                                 req_restart,
   input  logic                                 q_full,
   output logic                                 q_push,
   output stg_pkg::tone_item_type               q_item
);

   stg_pkg::csr_type csr_ff;

   logic [31:0] phase_ff,   phase_in;
   logic [31:0] inc_ff,     inc_in;
   logic [31:0] gain_ff,    gain_in;
   logic [15:0] index_ff,   index_in;
   logic [15:0] delay_ff,   delay_in;
   logic        running_ff, running_in;

   logic        accept;
   logic [31:0] phase_e;
   logic [31:0] inc_e;
   logic [31:0] gain_e;
   logic [15:0] index_e;
   logic [15:0] delay_e;
   logic        run_e;
   logic [31:0] phase_sum;
   logic [63:0] inc_prod;
   logic [63:0] gain_prod;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.start_increment <= '0;
         csr_ff.sweep_ratio     <= stg_pkg::UNITY_SWEEP;
         csr_ff.wave_shape      <= stg_pkg::WAVE_SINE;
         csr_ff.start_gain      <= '0;
         csr_ff.decay_ratio     <= '0;
         csr_ff.tone_length     <= '0;
         csr_ff.start_delay     <= '0;
      end else if (csr_we) begin
         unique case (stg_pkg::csr_index_type'(csr_index))
            stg_pkg::CSR_START_INCREMENT: csr_ff.start_increment <= csr_wdata[30:0];
            stg_pkg::CSR_SWEEP_RATIO:     csr_ff.sweep_ratio     <= csr_wdata[31:0];
            stg_pkg::CSR_WAVE_SHAPE:
               csr_ff.wave_shape <= stg_pkg::wave_shape_type'(csr_wdata[1:0]);
            stg_pkg::CSR_START_GAIN:      csr_ff.start_gain      <= csr_wdata[15:0];
            stg_pkg::CSR_DECAY_RATIO:     csr_ff.decay_ratio     <= csr_wdata[31:0];
            stg_pkg::CSR_TONE_LENGTH:     csr_ff.tone_length     <= csr_wdata[15:0];
            stg_pkg::CSR_START_DELAY:     csr_ff.start_delay     <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   assign accept = req_push && !q_full;
   assign q_push = accept;

   always_comb begin
      // A restart reloads the tone state before this beat is worked on.
      phase_e   = req_restart ? 32'd0 : phase_ff;
      inc_e     = req_restart ? {1'b0, csr_ff.start_increment} : inc_ff;
      gain_e    = req_restart ? {csr_ff.start_gain, 16'd0} : gain_ff;
      index_e   = req_restart ? 16'd0 : index_ff;
      delay_e   = req_restart ? csr_ff.start_delay : delay_ff;
      run_e     = req_restart || running_ff;

      phase_sum = phase_e + inc_e;
      inc_prod  = 64'(inc_e) * 64'(csr_ff.sweep_ratio);
      gain_prod = 64'(gain_e) * 64'(csr_ff.decay_ratio);

      phase_in   = phase_e;
      inc_in     = inc_e;
      gain_in    = gain_e;
      index_in   = index_e;
      delay_in   = delay_e;
      running_in = run_e;

      q_item.phase = phase_sum;
      q_item.gain  = gain_e;
      q_item.shape = csr_ff.wave_shape;
      q_item.tone  = 1'b0;
      q_item.busy  = 1'b0;
      q_item.last  = 1'b0;

      if (run_e) begin
         if (delay_e != 16'd0) begin
            delay_in    = delay_e - 16'd1;
            q_item.busy = 1'b1;
         end else if (index_e >= csr_ff.tone_length) begin
            running_in = 1'b0;
         end else begin
            phase_in    = phase_sum;
            q_item.tone = 1'b1;
            q_item.busy = 1'b1;
            q_item.last = ((index_e + 16'd1) == csr_ff.tone_length);
            // Q2.30 sweep saturates at the top of the increment range.
            inc_in      = (inc_prod[63:62] != 2'b00) ? 32'hFFFF_FFFF : inc_prod[61:30];
            gain_in     = gain_prod[63:32];
            index_in    = index_e + 16'd1;
            if (q_item.last) begin
               running_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= '0;
         inc_ff     <= '0;
         gain_ff    <= '0;
         index_ff   <= '0;
         delay_ff   <= '0;
         running_ff <= 1'b0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         inc_ff     <= inc_in;
         gain_ff    <= gain_in;
         index_ff   <= index_in;
         delay_ff   <= delay_in;
         running_ff <= running_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_last_ends_tone: assert property (@(posedge clock) disable iff (reset)
      (accept && q_item.last) |=> !running_ff)
      else $error("tone still running after its final beat");

   a_idle_no_delay: assert property (@(posedge clock) disable iff (reset)
      !running_ff |-> (delay_ff == 16'd0))
      else $error("delay count left over while idle");

   a_tone_is_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && q_item.tone) |-> q_item.busy)
      else $error("tone beat handed on without busy set");
`endif

endmodule

/* rtl/core/stg_back.sv */
// Waveform pipeline of the swept tone generator: wave shaping with the sine table,
// gain multiply with saturation, and the result buffer. Depends on stg_pkg, stg_queue.
module stg_back #(
   parameter int unsigned RSP_DEPTH = stg_pkg::RSP_QUEUE_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     mid_empty,
   input  stg_pkg::tone_item_type   mid_item,
   output logic                     mid_pop,
   input  logic                     rsp_pop,
   output logic                     rsp_empty,
   output logic signed [15:0]       rsp_sample,
   output logic                     rsp_busy_res,
   output logic                     rsp_last
);

   localparam int unsigned CNT_W = $clog2(RSP_DEPTH + 1);

   logic [1:0]                      quad;
   logic [stg_pkg::SINE_IDX_W-1:0]  rom_idx;
   logic [17:0]                     tri_u;
   logic [17:0]                     tri_d;
   logic [15:0]                     mag_a;
   logic                            neg_a;

   logic        a_v_ff;
   logic [15:0] a_mag_ff;
   logic        a_neg_ff;
   logic [31:0] a_gain_ff;
   logic        a_busy_ff;
   logic        a_last_ff;

   logic [47:0]           prod;
   logic [14:0]           mag_b;
   stg_pkg::rsp_beat_type beat_b;
   stg_pkg::rsp_beat_type beat_out;
   logic [CNT_W-1:0]      rsp_count;
   logic                  rsp_full;

   // Pop only when the result buffer has room for this beat and the one ahead of it.
   assign mid_pop = !mid_empty &&
      ((CNT_W + 1)'(rsp_count) + (CNT_W + 1)'(a_v_ff) < (CNT_W + 1)'(RSP_DEPTH));

   always_comb begin
      quad    = mid_item.phase[31:30];
      rom_idx = mid_item.phase[29 -: stg_pkg::SINE_IDX_W];
      if (quad[0]) begin
         rom_idx = ~rom_idx;
      end
      tri_u = {1'b0, mid_item.phase[31:15]};
      tri_d = '0;
      mag_a = '0;
      neg_a = 1'b0;
      unique case (mid_item.shape)
         stg_pkg::WAVE_SINE: begin
            mag_a = stg_pkg::SINE_ROM[rom_idx];
            neg_a = quad[1];
         end
         stg_pkg::WAVE_SQUARE: begin
            mag_a = stg_pkg::FULL_SCALE;
            neg_a = mid_item.phase[31];
         end
         stg_pkg::WAVE_TRIANGLE: begin
            // Rising, falling through zero, then rising back; peaks clamp to full scale.
            if (tri_u < 18'd32768) begin
               tri_d = tri_u;
            end else if (tri_u <= 18'd65536) begin
               tri_d = 18'd65536 - tri_u;
            end else if (tri_u < 18'd98304) begin
               tri_d = tri_u - 18'd65536;
               neg_a = 1'b1;
            end else begin
               tri_d = 18'd131072 - tri_u;
               neg_a = 1'b1;
            end
            mag_a = tri_d[15] ? stg_pkg::FULL_SCALE : tri_d[15:0];
         end
         stg_pkg::WAVE_SAW: begin
            neg_a = !mid_item.phase[31];
            mag_a = mid_item.phase[31] ? {1'b0, mid_item.phase[30:16]}
                                       : 16'd32768 - {1'b0, mid_item.phase[30:16]};
         end
         default: ;
      endcase
      if (!mid_item.tone) begin
         mag_a = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
      end else begin
         a_v_ff <= mid_pop;
      end
   end

   always_ff @(posedge clock) begin
      if (mid_pop) begin
         a_mag_ff  <= mag_a;
         a_neg_ff  <= neg_a;
         a_gain_ff <= mid_item.gain;
         a_busy_ff <= mid_item.busy;
         a_last_ff <= mid_item.last;
      end
   end

   always_comb begin
      // Magnitude times Q1.31 gain, truncated toward zero, then sign restored.
      prod  = 48'(a_mag_ff) * 48'(a_gain_ff);
      mag_b = (prod[47:46] != 2'b00) ? stg_pkg::FULL_SCALE[14:0] : prod[45:31];
      beat_b.sample   = a_neg_ff ? -$signed({1'b0, mag_b}) : $signed({1'b0, mag_b});
      beat_b.busy_res = a_busy_ff;
      beat_b.last     = a_last_ff;
   end

   stg_queue #(
      .DEPTH  (RSP_DEPTH),
      .DATA_W ($bits(stg_pkg::rsp_beat_type))
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (a_v_ff),
      .push_data (beat_b),
      .pop       (rsp_pop),
      .pop_data  (beat_out),
      .full      (rsp_full),
      .empty     (rsp_empty),
      .count     (rsp_count)
   );

   assign rsp_sample   = beat_out.sample;
   assign rsp_busy_res = beat_out.busy_res;
   assign rsp_last     = beat_out.last;

`ifndef NO_ASSERTIONS
   a_room_for_beat: assert property (@(posedge clock) disable iff (reset)
      a_v_ff |-> !rsp_full)
      else $error("pipeline beat arrived at a full result buffer");

   a_silent_not_last: assert property (@(posedge clock) disable iff (reset)
      (a_v_ff && a_last_ff) |-> a_busy_ff)
      else $error("final beat of a tone marked idle");

   a_pop_credit: assert property (@(posedge clock) disable iff (reset)
      mid_pop |=> (rsp_count < CNT_W'(RSP_DEPTH)))
      else $error("result buffer filled while a beat was in flight");
`endif

endmodule

/* rtl/core/swept_tone_generator.sv */
// Swept tone generator, top level. A result beat goes from the hand-off queue through the
// registered wave-shaping stage into the result buffer, from which it can be popped.
// Throughput: one request and one result beat per cycle while results are popped, set by
// the phase, sweep and decay update in the sequencer. Reset is synchronous and active high;
// it restores register defaults and empties both queues, and there is no clearing pass.
// Depends on stg_pkg, stg_queue, stg_front and stg_back.
module swept_tone_generator #(
   parameter int unsigned MID_QUEUE_DEPTH = stg_pkg::MID_QUEUE_DEPTH,
   parameter int unsigned RSP_QUEUE_DEPTH = stg_pkg::RSP_QUEUE_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   // Request channel: one beat per sample tick.
   input  logic                             req_push,
   output logic                             req_full,
   input  logic                             req_restart,
   // Result channel: one beat per request beat, in order.
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output logic signed [15:0]               rsp_sample,
   output logic                             rsp_busy_res,
   output logic                             rsp_last,
   // Configuration write port.
   input  logic                             csr_we,
   input  logic [stg_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [stg_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   // The sequencer owns all state that one sample hands to the next: the phase
   // accumulator, the swept increment, the decaying gain and the delay and sample
   // counters. It finishes a sample's state update in the cycle the beat is accepted,
   // so back-to-back ticks never wait on each other.
   stg_pkg::tone_item_type front_item;
   stg_pkg::tone_item_type mid_item;
   logic                   front_push;
   logic                   mid_full;
   logic                   mid_empty;
   logic                   mid_pop;

   // The request side only stalls when the hand-off queue is full, which happens
   // only after the result side has been held off long enough to back up the result buffer.
   assign req_full = mid_full;

   stg_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_push    (req_push),
      .req_restart (req_restart),
      .q_full      (mid_full),
      .q_push      (front_push),
      .q_item      (front_item)
   );

   // The hand-off queue decouples the sequencer from the waveform pipeline, so a
   // stalled result consumer does not freeze the state update until it fills.
   stg_queue #(
      .DEPTH  (MID_QUEUE_DEPTH),
      .DATA_W ($bits(stg_pkg::tone_item_type))
   ) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_data (front_item),
      .pop       (mid_pop),
      .pop_data  (mid_item),
      .full      (mid_full),
      .empty     (mid_empty),
      .count     ()
   );

   // The waveform pipeline shapes the wave in one stage, applies the gain with
   // saturation in the next, and keeps finished beats in its result buffer.
   stg_back #(
      .RSP_DEPTH (RSP_QUEUE_DEPTH)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .mid_empty    (mid_empty),
      .mid_item     (mid_item),
      .mid_pop      (mid_pop),
      .rsp_pop      (rsp_pop),
      .rsp_empty    (rsp_empty),
      .rsp_sample   (rsp_sample),
      .rsp_busy_res (rsp_busy_res),
      .rsp_last     (rsp_last)
   );

endmodule

/* tb/sv/swept_tone_generator_tb.sv */
// Self-checking testbench for the swept tone generator: directed tone sequences, then random ones.
// It predicts every result beat from its own model of the oscillator and compares them in order.
// Depends on stg_pkg and swept_tone_generator.
module swept_tone_generator_tb;

   // Full-scale level of a Q1.15 wave, kept as a signed int so the wave math stays signed.
   localparam int PEAK = 32767;
   // The receiver's one forced hold-off. With two 4-deep queues in the block, this is far
   // longer than needed to fill it up and push req_full high.
   localparam int HOLD_CYCLES = 96;
   // The longest correct stretch without any handshake is the hold-off above plus a
   // phase change (seven register writes and the drain wait). The limit is set many
   // times above that.
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_BEATS = 1050;

   // Receiver stall styles, picked anew for every random phase.
   typedef enum logic [1:0] {
      POP_ALWAYS,
      POP_COIN,
      POP_SPARSE,
      POP_PERIODIC
   } pop_style_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                             req_push    = 1'b0;
   logic                             req_full;
   logic                             req_restart = 1'b0;
   logic                             rsp_empty;
   logic                             rsp_pop     = 1'b0;
   logic signed [15:0]               rsp_sample;
   logic                             rsp_busy_res;
   logic                             rsp_last;
   logic                             csr_we      = 1'b0;
   logic [stg_pkg::CSR_INDEX_W-1:0]  csr_index   = '0;
   logic [stg_pkg::CSR_DATA_W-1:0]   csr_wdata   = '0;

   always #5 clock = ~clock;

   swept_tone_generator u_top (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_restart  (req_restart),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_sample   (rsp_sample),
      .rsp_busy_res (rsp_busy_res),
      .rsp_last     (rsp_last),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // ------------------------------------------------------------------
   // Oscillator model: our own copy of the registers and the tone state.
   // ------------------------------------------------------------------
   stg_pkg::csr_type tone_regs;
   logic [31:0]      osc_phase;
   logic [31:0]      osc_step;
   logic [31:0]      osc_gain;
   logic [15:0]      osc_count;
   logic [15:0]      osc_delay;
   logic             osc_on;
   logic [15:0]      quarter_sine [stg_pkg::SINE_TABLE_DEPTH];

   // One quarter-wave table entry: sine at the bin center by a nested Taylor series in
   // Q2.30, then rounded to Q1.15.
   function automatic logic [15:0] quarter_sine_bin(int i);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] v;
      x  = (stg_pkg::HALF_PI_Q30 * 64'(2 * i + 1)) / 64'(2 * stg_pkg::SINE_TABLE_DEPTH);
      x2 = (x * x) >> 30;
      t  = stg_pkg::ONE_Q30;
      t  = stg_pkg::ONE_Q30 - ((x2 * t) >> 30) / 64'd110;
      t  = stg_pkg::ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
      t  = stg_pkg::ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
      t  = stg_pkg::ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
      t  = stg_pkg::ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
      v  = ((((x * t) >> 30) * 64'(PEAK)) + 64'h2000_0000) >> 30;
      return (v > 64'(PEAK)) ? 16'(PEAK) : v[15:0];
   endfunction

   // Signed Q1.15 wave level at a given phase.
   function automatic int wave_level(logic [31:0] p, stg_pkg::wave_shape_type shape);
      int                              v;
      logic [stg_pkg::SINE_IDX_W-1:0]  bin;
      case (shape)
         stg_pkg::WAVE_SQUARE: v = p[31] ? -PEAK : PEAK;
         stg_pkg::WAVE_TRIANGLE: begin
            v = int'(p[31:15]);
            if (v >= 98304) v = v - 131072;
            else if (v >= 32768) v = 65536 - v;
            if (v > PEAK) v = PEAK;
            else if (v < -PEAK) v = -PEAK;
         end
         stg_pkg::WAVE_SAW: v = int'(p[31:16]) - 32768;
         default: begin
            // Odd quadrants run the table backward, the upper half is negated.
            bin = p[30] ? ~p[29 -: stg_pkg::SINE_IDX_W] : p[29 -: stg_pkg::SINE_IDX_W];
            v = int'(quarter_sine[bin]);
            if (p[31]) v = -v;
         end
      endcase
      return v;
   endfunction

   // Advances the oscillator by one tick and returns the result beat that tick produces.
   function automatic stg_pkg::rsp_beat_type next_tone_beat(logic restart);
      stg_pkg::rsp_beat_type beat;
      int                    wave;
      int                    level;
      logic [63:0]           wide;
      beat = '0;
      if (restart) begin
         osc_step  = {1'b0, tone_regs.start_increment};
         osc_gain  = {tone_regs.start_gain, 16'h0000};
         osc_phase = '0;
         osc_count = '0;
         osc_delay = tone_regs.start_delay;
         osc_on    = 1'b1;
      end
      if (osc_on) begin
         if (osc_delay != 0) begin
            osc_delay = osc_delay - 16'd1;
            beat.busy_res = 1'b1;
         end else if (osc_count >= tone_regs.tone_length) begin
            // The length register is read live, so a lowered length ends the tone here.
            osc_on = 1'b0;
         end else begin
            osc_phase = osc_phase + osc_step;
            wave = wave_level(osc_phase, tone_regs.wave_shape);
            wide = (64'(wave < 0 ? -wave : wave) * 64'(osc_gain)) >> 31;
            level = (wide > 64'(PEAK)) ? PEAK : int'(wide[15:0]);
            beat.sample   = 16'(wave < 0 ? -level : level);
            beat.busy_res = 1'b1;
            beat.last     = (17'(osc_count) + 17'd1 == 17'(tone_regs.tone_length));
            wide = (64'(osc_step) * 64'(tone_regs.sweep_ratio)) >> 30;
            osc_step = (wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
            wide = (64'(osc_gain) * 64'(tone_regs.decay_ratio)) >> 32;
            osc_gain = wide[31:0];
            osc_count = osc_count + 16'd1;
            if (beat.last) osc_on = 1'b0;
         end
      end
      return beat;
   endfunction

   // ------------------------------------------------------------------
   // Shared bookkeeping.
   // ------------------------------------------------------------------
   logic                  pending_restarts [$];
   stg_pkg::rsp_beat_type expected_beats [$];
   stg_pkg::rsp_beat_type want;
   pop_style_type pop_style   = POP_ALWAYS;
   logic          sender_gaps = 1'b0;
   int            mismatches  = 0;
   int            beats_sent  = 0;
   int            restarts_sent = 0;
   int            results_seen  = 0;
   int            tone_ends     = 0;
   int            beats_planned = 0;
   int            settings_used = 0;
   int            burst_left  = 0;
   int            gap_left    = 0;
   int            hold_left   = 0;
   int            popped      = 0;
   int            quiet_cycles = 0;
   logic [2:0]    pop_tick    = '0;
   logic          held_once   = 1'b0;

   task automatic flag_mismatch(string what);
      mismatches++;
      $display("tb: result beat %0d: %s", results_seen, what);
   endtask

   // ------------------------------------------------------------------
   // Driver. It offers the oldest pending item and holds it until it is taken. When
   // sender_gaps is set it works in bursts with random gaps in between; otherwise it
   // pushes back to back.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_push    <= 1'b0;
         req_restart <= 1'b0;
         burst_left  = 0;
         gap_left    = 0;
      end else begin
         if (req_push && !req_full) pending_restarts.delete(0);
         if (!(req_push && req_full)) begin
            if (gap_left != 0) begin
               req_push <= 1'b0;
               gap_left--;
            end else if (pending_restarts.size() == 0) begin
               req_push <= 1'b0;
            end else begin
               req_push    <= 1'b1;
               req_restart <= pending_restarts[0];
               if (sender_gaps) begin
                  if (burst_left <= 1) begin
                     burst_left = $urandom_range(1, 12);
                     gap_left   = $urandom_range(1, 10);
                  end else begin
                     burst_left--;
                  end
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Receiver. It stalls in the style of the current phase. Once, when enough results
   // have gone by and the sender still has plenty queued, it holds off for HOLD_CYCLES
   // so that the block fills up and stalls its input.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop   <= 1'b0;
         hold_left = 0;
         popped    = 0;
      end else begin
         if (rsp_pop && !rsp_empty) popped++;
         pop_tick <= pop_tick + 3'd1;
         if (hold_left != 0) begin
            rsp_pop <= 1'b0;
            hold_left--;
         end else if (!held_once && popped >= 300 && pending_restarts.size() >= 24) begin
            held_once = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rsp_pop   <= 1'b0;
         end else begin
            case (pop_style)
               POP_ALWAYS:   rsp_pop <= 1'b1;
               POP_COIN:     rsp_pop <= 1'($urandom_range(0, 1));
               POP_SPARSE:   rsp_pop <= ($urandom_range(0, 3) == 0);
               POP_PERIODIC: rsp_pop <= (pop_tick[1:0] != 2'd0);
            endcase
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor. Every accepted result beat is checked against the oldest expectation, and
   // every accepted request beat runs the oscillator model one tick.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_pop && !rsp_empty) begin
            results_seen++;
            if (rsp_last) tone_ends++;
            if (expected_beats.size() == 0) begin
               flag_mismatch("result beat with nothing expected");
            end else begin
               want = expected_beats.pop_front();
               if (rsp_sample !== want.sample)
                  flag_mismatch($sformatf("sample %0d, expected %0d", rsp_sample, want.sample));
               if (rsp_busy_res !== want.busy_res)
                  flag_mismatch($sformatf("busy_res %b, expected %b", rsp_busy_res,
                                          want.busy_res));
               if (rsp_last !== want.last)
                  flag_mismatch($sformatf("last %b, expected %b", rsp_last, want.last));
            end
         end
         if (req_push && !req_full) begin
            expected_beats.push_back(next_tone_beat(req_restart));
            beats_sent++;
            if (req_restart) restarts_sent++;
         end
      end
   end

   // Watchdog: any handshake or register write counts as progress.
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) || csr_we) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: no handshake for %0d cycles, %0d results still expected",
                     quiet_cycles, expected_beats.size());
            $display("tb: failure");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers.
   // ------------------------------------------------------------------

   // One register write. Only called while nothing is in flight, so the model's copy can
   // follow right away.
   task automatic write_reg(stg_pkg::csr_index_type idx, logic [31:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we    <= 1'b0;
      case (idx)
         stg_pkg::CSR_START_INCREMENT: tone_regs.start_increment = data[30:0];
         stg_pkg::CSR_SWEEP_RATIO:     tone_regs.sweep_ratio     = data;
         stg_pkg::CSR_WAVE_SHAPE:
            tone_regs.wave_shape = stg_pkg::wave_shape_type'(data[1:0]);
         stg_pkg::CSR_START_GAIN:      tone_regs.start_gain      = data[15:0];
         stg_pkg::CSR_DECAY_RATIO:     tone_regs.decay_ratio     = data;
         stg_pkg::CSR_TONE_LENGTH:     tone_regs.tone_length     = data[15:0];
         stg_pkg::CSR_START_DELAY:     tone_regs.start_delay     = data[15:0];
      endcase
   endtask

   task automatic add_beat(logic restart);
      pending_restarts.push_back(restart);
      beats_planned++;
   endtask

   // A restart beat followed by a number of plain ticks.
   task automatic add_tone(int ticks);
      add_beat(1'b1);
      repeat (ticks) add_beat(1'b0);
   endtask

   // Waits until every item has gone in and every result has come out, then lets the
   // block's latency pass before anything is written.
   task automatic drain_phase();
      @(negedge clock);
      while (pending_restarts.size() != 0 || expected_beats.size() != 0 || req_push)
         @(negedge clock);
      repeat (4) @(posedge clock);
      settings_used++;
   endtask

   // Random register values lean toward audible settings (sweep and decay near one,
   // short tones) with the extremes mixed in.
   function automatic logic [31:0] pick_reg_value(stg_pkg::csr_index_type idx);
      int unsigned roll;
      roll = $urandom_range(0, 9);
      case (idx)
         stg_pkg::CSR_START_INCREMENT:
            if (roll == 0) return 32'h0;
            else if (roll == 1) return 32'h7FFF_FFFF;
            else if (roll < 6) return $urandom_range(0, 32'h00FF_FFFF);
            else return $urandom() & 32'h7FFF_FFFF;
         stg_pkg::CSR_SWEEP_RATIO:
            if (roll == 0) return 32'h0;
            else if (roll == 1) return 32'hFFFF_FFFF;
            else if (roll == 2) return $urandom();
            else return 32'h3FFF_8000 + $urandom_range(0, 32'h0001_0000);
         stg_pkg::CSR_WAVE_SHAPE:
            return $urandom_range(0, 3);
         stg_pkg::CSR_START_GAIN:
            if (roll < 3) return 32'd32768;
            else if (roll == 3) return 32'd0;
            else return $urandom_range(0, 32768);
         stg_pkg::CSR_DECAY_RATIO:
            if (roll == 0) return 32'h0;
            else if (roll == 1) return 32'hFFFF_FFFF;
            else if (roll == 2) return $urandom();
            else return 32'hFFFF_FFFF - $urandom_range(0, 32'h0100_0000);
         stg_pkg::CSR_TONE_LENGTH:
            if (roll == 0) return 32'd0;
            else if (roll == 1) return 32'd65535;
            else return $urandom_range(1, 40);
         default:
            if (roll == 0) return 32'd65535;
            else if (roll < 3) return $urandom_range(1, 6);
            else return 32'd0;
      endcase
   endfunction

   task automatic maybe_write(stg_pkg::csr_index_type idx);
      if ($urandom_range(0, 3) != 0) write_reg(idx, pick_reg_value(idx));
   endtask

   // A random phase: mostly restarts followed by a tick count that plays the tone out,
   // cuts it short or runs past its end, plus some beats of random restart noise.
   // It sometimes opens with plain ticks, so that a tone left running by the previous
   // phase continues under the newly written live registers.
   task automatic plan_random_phase();
      int budget;
      int span;
      int ticks;
      budget = beats_planned + $urandom_range(30, 90);
      if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 6)) add_beat(1'b0);
      while (beats_planned < budget) begin
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 8)) add_beat(1'($urandom_range(0, 1)));
         end else begin
            span = int'(tone_regs.start_delay) + int'(tone_regs.tone_length);
            if (span > 80) ticks = $urandom_range(1, 40);
            else if ($urandom_range(0, 3) == 0) ticks = $urandom_range(0, span);
            else ticks = (span == 0) ? $urandom_range(0, 3) : span - 1 + $urandom_range(0, 3);
            add_tone(ticks);
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Main sequence.
   // ------------------------------------------------------------------
   initial begin
      for (int i = 0; i < stg_pkg::SINE_TABLE_DEPTH; i++) quarter_sine[i] = quarter_sine_bin(i);
      tone_regs             = '0;
      tone_regs.sweep_ratio = stg_pkg::UNITY_SWEEP;
      tone_regs.wave_shape  = stg_pkg::WAVE_SINE;
      osc_phase = '0;
      osc_step  = '0;
      osc_gain  = '0;
      osc_count = '0;
      osc_delay = '0;
      osc_on    = 1'b0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Idle ticks after reset, then a restart with the reset registers: zero length
      // and zero delay, so even the restart tick itself comes back idle.
      @(negedge clock);
      add_beat(1'b0);
      add_beat(1'b0);
      add_tone(0);
      drain_phase();

      // Square wave at full gain with the largest step, sweep and decay: the step
      // saturates on the first update. Two delay beats, four tone beats, one idle beat.
      write_reg(stg_pkg::CSR_START_INCREMENT, 32'h7FFF_FFFF);
      write_reg(stg_pkg::CSR_SWEEP_RATIO,     32'hFFFF_FFFF);
      write_reg(stg_pkg::CSR_WAVE_SHAPE,      32'(stg_pkg::WAVE_SQUARE));
      write_reg(stg_pkg::CSR_START_GAIN,      32'd32768);
      write_reg(stg_pkg::CSR_DECAY_RATIO,     32'hFFFF_FFFF);
      write_reg(stg_pkg::CSR_TONE_LENGTH,     32'd4);
      write_reg(stg_pkg::CSR_START_DELAY,     32'd2);
      @(negedge clock);
      sender_gaps = 1'b1;
      pop_style   = POP_COIN;
      add_tone(6);
      drain_phase();

      // A sine tone is started and left running.
      write_reg(stg_pkg::CSR_START_INCREMENT, 32'h0123_4567);
      write_reg(stg_pkg::CSR_SWEEP_RATIO,     32'(stg_pkg::UNITY_SWEEP));
      write_reg(stg_pkg::CSR_WAVE_SHAPE,      32'(stg_pkg::WAVE_SINE));
      write_reg(stg_pkg::CSR_START_GAIN,      32'h6000);
      write_reg(stg_pkg::CSR_DECAY_RATIO,     32'hF000_0000);
      write_reg(stg_pkg::CSR_TONE_LENGTH,     32'd6);
      write_reg(stg_pkg::CSR_START_DELAY,     32'd0);
      @(negedge clock);
      add_tone(1);
      drain_phase();

      // The shape, sweep and decay change in the middle of that tone and act at once.
      write_reg(stg_pkg::CSR_WAVE_SHAPE,  32'(stg_pkg::WAVE_SAW));
      write_reg(stg_pkg::CSR_SWEEP_RATIO, 32'h0);
      write_reg(stg_pkg::CSR_DECAY_RATIO, 32'h0);
      @(negedge clock);
      add_beat(1'b0);
      drain_phase();

      // The length drops below the samples already played, so the next tick is idle.
      write_reg(stg_pkg::CSR_TONE_LENGTH, 32'd1);
      @(negedge clock);
      add_beat(1'b0);
      drain_phase();

      // Triangle with the longest delay and length. A restart during the delay reloads
      // it, and a later restart with no delay cuts straight into the tone.
      write_reg(stg_pkg::CSR_WAVE_SHAPE,      32'(stg_pkg::WAVE_TRIANGLE));
      write_reg(stg_pkg::CSR_START_INCREMENT, 32'h0800_0000);
      write_reg(stg_pkg::CSR_SWEEP_RATIO,     32'(stg_pkg::UNITY_SWEEP));
      write_reg(stg_pkg::CSR_DECAY_RATIO,     32'hFFFF_FFFF);
      write_reg(stg_pkg::CSR_START_GAIN,      32'd32768);
      write_reg(stg_pkg::CSR_TONE_LENGTH,     32'd65535);
      write_reg(stg_pkg::CSR_START_DELAY,     32'd65535);
      @(negedge clock);
      pop_style = POP_ALWAYS;
      add_tone(2);
      add_tone(0);
      drain_phase();
      write_reg(stg_pkg::CSR_START_DELAY, 32'd0);
      @(negedge clock);
      add_tone(3);
      drain_phase();

      // Random phases, each with a fresh mix of registers and idling styles.
      beats_planned = 0;
      while (beats_planned < RANDOM_BEATS) begin
         maybe_write(stg_pkg::CSR_START_INCREMENT);
         maybe_write(stg_pkg::CSR_SWEEP_RATIO);
         maybe_write(stg_pkg::CSR_WAVE_SHAPE);
         maybe_write(stg_pkg::CSR_START_GAIN);
         maybe_write(stg_pkg::CSR_DECAY_RATIO);
         maybe_write(stg_pkg::CSR_TONE_LENGTH);
         maybe_write(stg_pkg::CSR_START_DELAY);
         @(negedge clock);
         pop_style   = pop_style_type'($urandom_range(0, 3));
         sender_gaps = ($urandom_range(0, 2) != 0);
         plan_random_phase();
         drain_phase();
      end

      repeat (6) @(posedge clock);
      $display("tb: %0d request beats with %0d restarts, %0d result beats, %0d tone ends",
               beats_sent, restarts_sent, results_seen, tone_ends);
      $display("tb: %0d register settings over all four shapes, input stall by hold-off %s",
               settings_used, held_once ? "reached" : "not reached");
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

/* swept_tone_generator.f */
rtl/core/stg_pkg.sv
rtl/core/stg_queue.sv
rtl/core/stg_front.sv
rtl/core/stg_back.sv
rtl/core/swept_tone_generator.sv
tb/sv/swept_tone_generator_tb.sv
